// ===== src/crf_pkg.sv =====
// crf_pkg: types, widths and codes shared by the circle raster framebuffer.
// Holds the operation and register codes and the controller/datapath structs.
// No dependencies.
package crf_pkg;

  // Screen geometry
  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;
  localparam int COL_W    = $clog2(SCREEN_W);
  localparam int ROW_W    = $clog2(SCREEN_H);

  // Field widths
  localparam int OP_W       = 2;
  localparam int COORD_W    = 12;
  localparam int RADIUS_W   = 9;
  localparam int PAIR_W     = 4;
  localparam int GLYPH_W    = 8;
  localparam int COLUMN_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Input tdata layout, lowest bit first
  localparam int FILL_LSB   = 0;
  localparam int CX_LSB     = 1;
  localparam int CY_LSB     = CX_LSB + COORD_W;
  localparam int RADIUS_LSB = CY_LSB + COORD_W;
  localparam int PAIR_LSB   = RADIUS_LSB + RADIUS_W;

  // Arithmetic widths (units of 1/16 pixel)
  localparam int D_W   = 14;           // signed center distance
  localparam int SQ_W  = 2 * D_W - 1;  // square of a distance
  localparam int R2_W  = 2 * RADIUS_W; // radius squared
  localparam logic [3:0] HALF_PIX = 4'd8;

  // Glyph reset values
  localparam logic [GLYPH_W-1:0] GLYPH_NONE_RST   = 8'd32;
  localparam logic [GLYPH_W-1:0] GLYPH_BOTTOM_RST = 8'd95;
  localparam logic [GLYPH_W-1:0] GLYPH_TOP_RST    = 8'd94;
  localparam logic [GLYPH_W-1:0] GLYPH_BOTH_RST   = 8'd67;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_NONE   = 2'd0,
    REG_GLYPH_BOTTOM = 2'd1,
    REG_GLYPH_TOP    = 2'd2,
    REG_GLYPH_BOTH   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_COL,
    ST_COL_FIN,
    ST_ROW_WB,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch input beat, restart row counter
    logic clr_wr;   // write fill row, next row
    logic row_rd;   // read row, square its dy
    logic row_load; // copy read row into row buffer, restart columns
    logic col_step; // test one column
    logic row_wb;   // write row buffer back
    logic row_inc;  // next row
    logic pair_rd;  // read both rows of a pair, restart columns
    logic emit;     // load output register with one glyph
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            row_last;
    logic            col_last;
    logic            row_out;   // whole row outside the circle
    logic            pair_off;  // row pair below the screen
    logic            out_free;  // output register can take a glyph
  } dp_stat_t;

endpackage

// ===== src/crf_ctrl.sv =====
// crf_ctrl: sequencer for clear, draw and read-row operations.
// Depends on crf_pkg; drives crf_datapath through dp_cmd_t.
module crf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  crf_pkg::dp_stat_t stat,
  output crf_pkg::dp_cmd_t  cmd
);

  crf_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      crf_pkg::ST_IDLE: begin
        // no beat is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = crf_pkg::ST_DECODE;
        end
      end
      crf_pkg::ST_DECODE: begin
        unique case (stat.op)
          crf_pkg::OP_CLEAR: state_nxt = crf_pkg::ST_CLEAR;
          crf_pkg::OP_DRAW:  state_nxt = crf_pkg::ST_ROW_RD;
          crf_pkg::OP_READ: begin
            if (stat.pair_off) begin
              state_nxt = crf_pkg::ST_IDLE;
            end else begin
              cmd.pair_rd = 1'b1;
              state_nxt   = crf_pkg::ST_EMIT;
            end
          end
          default: state_nxt = crf_pkg::ST_IDLE;
        endcase
      end
      crf_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.row_last) state_nxt = crf_pkg::ST_IDLE;
      end
      crf_pkg::ST_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = crf_pkg::ST_ROW_CHK;
      end
      crf_pkg::ST_ROW_CHK: begin
        // skip rows the circle cannot reach
        if (stat.row_out) begin
          cmd.row_inc = 1'b1;
          state_nxt   = stat.row_last ? crf_pkg::ST_IDLE : crf_pkg::ST_ROW_RD;
        end else begin
          cmd.row_load = 1'b1;
          state_nxt    = crf_pkg::ST_COL;
        end
      end
      crf_pkg::ST_COL: begin
        cmd.col_step = 1'b1;
        if (stat.col_last) state_nxt = crf_pkg::ST_COL_FIN;
      end
      crf_pkg::ST_COL_FIN: begin
        // last column test lands in the row buffer
        state_nxt = crf_pkg::ST_ROW_WB;
      end
      crf_pkg::ST_ROW_WB: begin
        cmd.row_wb  = 1'b1;
        cmd.row_inc = 1'b1;
        state_nxt   = stat.row_last ? crf_pkg::ST_IDLE : crf_pkg::ST_ROW_RD;
      end
      crf_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.col_last) state_nxt = crf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crf_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/crf_datapath.sv =====
// crf_datapath: row memory, circle test, glyph registers and output stage.
// Depends on crf_pkg; commanded by crf_ctrl.
module crf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crf_pkg::dp_cmd_t                    cmd,
  output crf_pkg::dp_stat_t                   stat,
  input  logic [crf_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [crf_pkg::OP_W-1:0]            in_tuser,
  input  logic                                cfg_valid,
  input  logic [crf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crf_pkg::GLYPH_W-1:0]         cfg_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [crf_pkg::GLYPH_W-1:0]         out_glyph,
  output logic [crf_pkg::COLUMN_W-1:0]        out_column,
  output logic                                out_tlast
);

  localparam int W  = crf_pkg::SCREEN_W;
  localparam int H  = crf_pkg::SCREEN_H;
  localparam int CW = crf_pkg::COL_W;
  localparam int RW = crf_pkg::ROW_W;
  localparam int DW = crf_pkg::D_W;

  // Latched operation
  logic [crf_pkg::OP_W-1:0]            op_r;
  logic                                fill_r;
  logic signed [crf_pkg::COORD_W-1:0]  cx_r, cy_r;
  logic [crf_pkg::R2_W-1:0]            r2_r;
  logic [crf_pkg::PAIR_W-1:0]          pair_r;
  logic [crf_pkg::RADIUS_W-1:0]        rad_in;

  // Counters
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;

  // Row memory with per-row valid bits
  logic [W-1:0]  mem [H];
  logic [H-1:0]  vld_r;
  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic [RW-1:0] rd_a_addr, rd_b_addr;
  logic [W-1:0]  rd_a_r, rd_b_r;
  logic          rd_a_vld_r, rd_b_vld_r, rd_b_on_r;

  // Pair addressing
  logic [crf_pkg::PAIR_W:0]   top_full;
  logic [crf_pkg::PAIR_W+1:0] bot_full;

  // Circle test
  logic signed [DW-1:0]     dx, dy;
  logic signed [2*DW-1:0]   dx_prod, dy_prod;
  logic [crf_pkg::SQ_W-1:0] dx_sq_r, dy_sq_r;
  logic [crf_pkg::SQ_W:0]   dist_sq;
  logic [CW-1:0]            chk_col_r;
  logic                     chk_vld_r;
  logic [W-1:0]             rowbuf_r;

  // Glyphs and output
  logic [crf_pkg::GLYPH_W-1:0] g_none_r, g_bottom_r, g_top_r, g_both_r;
  logic [crf_pkg::GLYPH_W-1:0] glyph_sel;
  logic                        top_bit, bot_bit;
  logic                        out_vld_r, out_last_r;
  logic [crf_pkg::GLYPH_W-1:0] out_glyph_r;
  logic [crf_pkg::COLUMN_W-1:0] out_col_r;

  assign rad_in   = in_tdata[crf_pkg::RADIUS_LSB +: crf_pkg::RADIUS_W];
  assign top_full = {pair_r, 1'b0};
  assign bot_full = {1'b0, top_full} + 1'b1;

  // Latch input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser;
      fill_r <= in_tdata[crf_pkg::FILL_LSB];
      cx_r   <= in_tdata[crf_pkg::CX_LSB +: crf_pkg::COORD_W];
      cy_r   <= in_tdata[crf_pkg::CY_LSB +: crf_pkg::COORD_W];
      pair_r <= in_tdata[crf_pkg::PAIR_LSB +: crf_pkg::PAIR_W];
      r2_r   <= crf_pkg::R2_W'(rad_in) * crf_pkg::R2_W'(rad_in);
    end
  end

  // Row and column counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      if (cmd.load) begin
        row_r <= '0;
      end else if (cmd.clr_wr || cmd.row_inc) begin
        row_r <= row_r + 1'b1;
      end
      if (cmd.row_load || cmd.pair_rd) begin
        col_r <= '0;
      end else if (cmd.col_step || cmd.emit) begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Memory ports
  assign wr_en     = cmd.clr_wr || cmd.row_wb;
  assign wr_addr   = row_r;
  assign wr_data   = cmd.clr_wr ? {W{fill_r}} : rowbuf_r;
  assign rd_a_addr = cmd.pair_rd ? RW'(top_full) : row_r;
  assign rd_b_addr = RW'(bot_full);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.row_rd || cmd.pair_rd) begin
      rd_a_r     <= mem[rd_a_addr];
      rd_a_vld_r <= vld_r[rd_a_addr];
    end
    if (cmd.pair_rd) begin
      rd_b_r     <= mem[rd_b_addr];
      rd_b_vld_r <= vld_r[rd_b_addr];
      rd_b_on_r  <= (int'(bot_full) < H);
    end
  end

  // Unwritten rows read as background
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Distances from pixel centers, squared
  assign dx = DW'(cx_r) - $signed(DW'({col_r, crf_pkg::HALF_PIX}));
  assign dy = DW'(cy_r) - $signed(DW'({row_r, crf_pkg::HALF_PIX}));
  assign dx_prod = dx * dx;
  assign dy_prod = dy * dy;
  assign dist_sq = {1'b0, dx_sq_r} + {1'b0, dy_sq_r};

  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      dy_sq_r <= dy_prod[crf_pkg::SQ_W-1:0];
    end
    if (cmd.col_step) begin
      dx_sq_r   <= dx_prod[crf_pkg::SQ_W-1:0];
      chk_col_r <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= cmd.col_step;
    end
  end

  // Row buffer: read-modify-write of one row
  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      rowbuf_r <= rd_a_vld_r ? rd_a_r : '0;
    end else if (chk_vld_r && (dist_sq <= (crf_pkg::SQ_W + 1)'(r2_r))) begin
      rowbuf_r[chk_col_r] <= 1'b1;
    end
  end

  // Glyph registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_none_r   <= crf_pkg::GLYPH_NONE_RST;
      g_bottom_r <= crf_pkg::GLYPH_BOTTOM_RST;
      g_top_r    <= crf_pkg::GLYPH_TOP_RST;
      g_both_r   <= crf_pkg::GLYPH_BOTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crf_pkg::REG_GLYPH_NONE:   g_none_r   <= cfg_data;
        crf_pkg::REG_GLYPH_BOTTOM: g_bottom_r <= cfg_data;
        crf_pkg::REG_GLYPH_TOP:    g_top_r    <= cfg_data;
        crf_pkg::REG_GLYPH_BOTH:   g_both_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Glyph for the current column
  assign top_bit = rd_a_vld_r && rd_a_r[col_r];
  assign bot_bit = rd_b_on_r && rd_b_vld_r && rd_b_r[col_r];

  always_comb begin
    case ({top_bit, bot_bit})
      2'b11:   glyph_sel = g_both_r;
      2'b10:   glyph_sel = g_top_r;
      2'b01:   glyph_sel = g_bottom_r;
      default: glyph_sel = g_none_r;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_glyph_r <= glyph_sel;
      out_col_r   <= crf_pkg::COLUMN_W'(col_r);
      out_last_r  <= (col_r == CW'(W - 1));
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_glyph  = out_glyph_r;
  assign out_column = out_col_r;
  assign out_tlast  = out_last_r;

  // Status
  assign stat.op       = op_r;
  assign stat.row_last = (row_r == RW'(H - 1));
  assign stat.col_last = (col_r == CW'(W - 1));
  assign stat.row_out  = ({1'b0, dy_sq_r} > (crf_pkg::SQ_W + 1)'(r2_r));
  assign stat.pair_off = (int'(top_full) >= H);
  assign stat.out_free = !out_vld_r || out_tready;

  // A glyph never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_vld_r || out_tready))
    else $error("glyph emitted over a pending beat");

  // Only one writer of the row memory per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && cmd.row_wb))
    else $error("clear and write-back collide");

  // The last column of a row is marked
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.col_last) |=> (out_tvalid && out_tlast))
    else $error("final glyph not marked last");

  // Row buffer is not written back while a column test is in flight
  a_wb_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_wb |-> !chk_vld_r)
    else $error("row written back before last test");

endmodule

// ===== src/circle_raster_framebuffer.sv =====
// circle_raster_framebuffer: top level of the one-bit framebuffer rasterizer.
// Depends on crf_pkg, crf_ctrl and crf_datapath.
//
// A 64 x 32 one-bit framebuffer held as one memory row per screen row. An
// input beat carries an operation in in_tuser: clear writes the fill value to
// every row, one row a cycle. Draw sets every pixel whose center is inside or
// on the circle; each row is first read and its vertical distance tested,
// and rows the circle reaches then take one pixel test per cycle, dx being
// squared by one multiplier and dy by a second, before the row is written back.
// Read-row emits SCREEN_W glyph beats, one per cycle while out_tready is
// high, the final one with tlast; an off-screen row pair and the unused
// operation code produce no beats. Input is taken only between operations;
// the last glyph may still sit in the output register while the next
// operation starts. Configuration writes are ready whenever reset is released.
module circle_raster_framebuffer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input: tdata = fill_value[0], center_x[12:1], center_y[24:13],
  //        radius[33:25], row_pair[37:34], zero pad [39:38]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [crf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [crf_pkg::OP_W-1:0]           in_tuser,   // op[1:0]
  // output: tdata = glyph[7:0], column[13:8], zero pad [15:14]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [crf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crf_pkg::GLYPH_W-1:0]        cfg_data
);

  crf_pkg::dp_cmd_t             cmd;
  crf_pkg::dp_stat_t            stat;
  logic [crf_pkg::GLYPH_W-1:0]  glyph;
  logic [crf_pkg::COLUMN_W-1:0] column;

  // glyph registers hold their reset values while reset is held
  assign cfg_ready = rst_n;

  crf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_glyph  (glyph),
    .out_column (column),
    .out_tlast  (out_tlast)
  );

  // Pack output beat
  assign out_tdata = {{(crf_pkg::OUT_TDATA_W - crf_pkg::GLYPH_W - crf_pkg::COLUMN_W){1'b0}},
                      column, glyph};

endmodule
